/* rtl/sbcc_pkg.sv */
// Shared types and constants for the segment/box collision checker.
// No dependencies.
package sbcc_pkg;

    localparam int COORD_WIDTH = 32;
    // coordinate differences carry two extra bits
    localparam int DIFF_WIDTH  = COORD_WIDTH + 2;

    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_SEGMENT  = 2'd1;
    localparam logic [1:0] OP_POINT    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic CFG_COUNT     = 1'b0;
    localparam logic CFG_TOLERANCE = 1'b1;

    // segment classes
    localparam logic [1:0] KIND_VERT  = 2'd0;
    localparam logic [1:0] KIND_HORIZ = 2'd1;
    localparam logic [1:0] KIND_GEN   = 2'd2;

    // request to the cross-product compare unit: sign of a*b - c*d
    typedef struct packed {
        logic                  start;
        logic [DIFF_WIDTH-1:0] a;
        logic [DIFF_WIDTH-1:0] b;
        logic [DIFF_WIDTH-1:0] c;
        logic [DIFF_WIDTH-1:0] d;
    } xprod_req_t;

    typedef struct packed {
        logic done;
        logic neg;
        logic zero;
    } xprod_rsp_t;

endpackage

/* rtl/segment_box_collision_check.sv */
// Top level of the segment/box collision checker: obstacle table, sequencer.
// Uses sbcc_pkg, sbcc_ram and sbcc_xprod.
// A point check walks the N active entries once; a segment check walks them for
// both end points and then once more (N = active entries), one entry read per step of the
// table walk and, for a general segment, edge tests through the shared cross-product unit.
// One request at a time. Reset clears count to 0, tolerance to 1; the table
// itself is not cleared.
module segment_box_collision_check
    import sbcc_pkg::*;
#(
    parameter int MAX_OBSTACLES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // operation, obstacle_index, box_left, box_right, box_bottom, box_top,
    // x_start, y_start, x_end, y_end
    input  logic [((6+8*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // path_free
    output logic [7:0]                     m_tdata,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [15:0]                    cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int IW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int NW = $clog2(MAX_OBSTACLES + 1);
    localparam int DW = DIFF_WIDTH;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_PTEST = 4'd2;
    localparam logic [3:0] ST_CLASS = 4'd3;
    localparam logic [3:0] ST_SRD   = 4'd4;
    localparam logic [3:0] ST_SWAIT = 4'd5;
    localparam logic [3:0] ST_SEDGE = 4'd6;
    localparam logic [3:0] ST_XWAIT = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;
    localparam logic [3:0] ST_RWAIT = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [4:0]    count_reg;
    logic [15:0]   tol_reg;
    logic [NW-1:0] active_n;
    logic [NW-1:0] idx_reg, idx_next;
    logic          pass_reg, pass_next;   // 0: start point, 1: end point
    logic          seg_reg, seg_next;
    logic [1:0]    kind_reg, kind_next;
    logic [1:0]    edge_reg, edge_next;
    logic          sub_reg, sub_next;     // 0: lo compare, 1: hi compare
    logic          free_reg, free_next;
    logic          res_reg, res_next;     // result held on the output
    logic          out_v_reg, out_v_next;

    logic signed [CW-1:0] xs_reg, ys_reg, xe_reg, ye_reg;
    logic [1:0]           op_in;
    logic [3:0]           oidx_in;
    logic signed [CW-1:0] in_l, in_r, in_b, in_t, in_xs, in_ys, in_xe, in_ye;

    assign op_in   = s_tdata[1:0];
    assign oidx_in = s_tdata[5:2];
    assign in_l    = s_tdata[6+0*CW +: CW];
    assign in_r    = s_tdata[6+1*CW +: CW];
    assign in_b    = s_tdata[6+2*CW +: CW];
    assign in_t    = s_tdata[6+3*CW +: CW];
    assign in_xs   = s_tdata[6+4*CW +: CW];
    assign in_ys   = s_tdata[6+5*CW +: CW];
    assign in_xe   = s_tdata[6+6*CW +: CW];
    assign in_ye   = s_tdata[6+7*CW +: CW];

    logic accept;
    logic wr_en;
    assign accept = s_tvalid && s_tready;
    assign wr_en  = accept && (op_in == OP_WRITE) && ({28'd0, oidx_in} < MAX_OBSTACLES);

    logic [IW-1:0]        raddr;
    logic [IW-1:0]        waddr;
    logic [4*CW-1:0]      rdata;
    logic signed [CW-1:0] bl, br, bb, bt;

    assign raddr = idx_reg[IW-1:0];
    assign waddr = IW'(oidx_in);

    sbcc_ram #(.WIDTH(4*CW), .DEPTH(MAX_OBSTACLES)) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata ({in_t, in_b, in_r, in_l}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign bl = rdata[0*CW +: CW];
    assign br = rdata[1*CW +: CW];
    assign bb = rdata[2*CW +: CW];
    assign bt = rdata[3*CW +: CW];

    assign active_n = (count_reg > MAX_OBSTACLES) ? NW'(MAX_OBSTACLES)
                                                 : NW'(count_reg);

    // point test on the entry just read
    logic signed [CW-1:0] px, py;
    logic                 phit;
    assign px   = pass_reg ? xe_reg : xs_reg;
    assign py   = pass_reg ? ye_reg : ys_reg;
    assign phit = (px >= bl) && (px <= br) && (py >= bb) && (py <= bt);

    // segment classification
    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0]        adx, ady;
    logic [1:0]           kind_c;
    assign dx  = DW'(xe_reg) - DW'(xs_reg);
    assign dy  = DW'(ye_reg) - DW'(ys_reg);
    assign adx = dx[DW-1] ? -dx : dx;
    assign ady = dy[DW-1] ? -dy : dy;
    assign kind_c = ((dx == '0) || (adx < DW'(tol_reg))) ? KIND_VERT :
                    ((dy == '0) || (ady < DW'(tol_reg))) ? KIND_HORIZ : KIND_GEN;

    function automatic logic span_ov(input logic signed [CW-1:0] s, e, lo, hi);
        span_ov = (s >= lo && s <= hi) || (e >= lo && e <= hi) ||
                  (s <= lo && e >= hi) || (e <= lo && s >= hi);
    endfunction

    logic axis_hit;
    assign axis_hit = (kind_reg == KIND_VERT)
        ? ((xe_reg >= bl) && (xe_reg <= br) && span_ov(ys_reg, ye_reg, bb, bt))
        : ((ye_reg >= bb) && (ye_reg <= bt) && span_ov(xs_reg, xe_reg, bl, br));

    // edge selection: left, right on axis x; bottom, top on axis y
    logic signed [CW-1:0] e_pos, e_lo, e_hi, a0, a1, b0;
    logic signed [DW-1:0] da, db;
    always_comb
    begin
        case (edge_reg)
            2'd0:
            begin
                e_pos = bl; e_lo = bb; e_hi = bt;
                a0 = xs_reg; a1 = xe_reg; b0 = ys_reg; da = dx; db = dy;
            end
            2'd1:
            begin
                e_pos = br; e_lo = bb; e_hi = bt;
                a0 = xs_reg; a1 = xe_reg; b0 = ys_reg; da = dx; db = dy;
            end
            2'd2:
            begin
                e_pos = bb; e_lo = bl; e_hi = br;
                a0 = ys_reg; a1 = ye_reg; b0 = xs_reg; da = dy; db = dx;
            end
            default:
            begin
                e_pos = bt; e_lo = bl; e_hi = br;
                a0 = ys_reg; a1 = ye_reg; b0 = xs_reg; da = dy; db = dx;
            end
        endcase
    end

    logic in_range;
    assign in_range = (e_pos >= a0 && e_pos <= a1) || (e_pos >= a1 && e_pos <= a0);

    xprod_req_t xreq;
    xprod_rsp_t xrsp;
    logic       xstart;
    always_comb
    begin
        xreq.start = xstart;
        xreq.a = (sub_reg ? (DW'(e_hi) - DW'(b0)) : (DW'(e_lo) - DW'(b0)));
        xreq.b = da;
        xreq.c = db;
        xreq.d = DW'(e_pos) - DW'(a0);
    end

    sbcc_xprod u_xprod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (xreq),
        .rsp   (xrsp)
    );

    // s*cmp > 0 -> miss at lo; s*cmp < 0 -> miss at hi
    logic pos_cmp, neg_cmp;
    assign pos_cmp = !xrsp.neg && !xrsp.zero;
    assign neg_cmp = xrsp.neg;
    logic miss;
    assign miss = sub_reg ? (da[DW-1] ? pos_cmp : neg_cmp)
                          : (da[DW-1] ? neg_cmp : pos_cmp);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        seg_next   = seg_reg;
        kind_next  = kind_reg;
        edge_next  = edge_reg;
        sub_next   = sub_reg;
        free_next  = free_reg;
        res_next   = res_reg;
        out_v_next = out_v_reg;
        xstart     = 1'b0;
        if (out_v_reg && m_tready)
        begin
            out_v_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op_in == OP_SEGMENT || op_in == OP_POINT))
                begin
                    seg_next   = (op_in == OP_SEGMENT);
                    idx_next   = '0;
                    pass_next  = 1'b0;
                    free_next  = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (idx_reg >= active_n)
                begin
                    if (seg_reg && !pass_reg)
                    begin
                        pass_next = 1'b1;
                        idx_next  = '0;
                    end
                    else if (seg_reg)
                    begin
                        state_next = ST_CLASS;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    state_next = ST_PTEST;
                end
            end
            ST_PTEST:
            begin
                if (phit)
                begin
                    free_next  = 1'b0;
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_CLASS:
            begin
                kind_next  = kind_c;
                idx_next   = '0;
                state_next = ST_SRD;
            end
            ST_SRD:
            begin
                edge_next = 2'd0;
                sub_next  = 1'b0;
                if (idx_reg >= active_n)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT:
            begin
                if (kind_reg != KIND_GEN)
                begin
                    if (axis_hit)
                    begin
                        free_next  = 1'b0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SRD;
                    end
                end
                else
                begin
                    state_next = ST_SEDGE;
                end
            end
            ST_SEDGE:
            begin
                if (!in_range)
                begin
                    sub_next = 1'b0;
                    if (edge_reg == 2'd3)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SRD;
                    end
                    else
                    begin
                        edge_next = edge_reg + 1'b1;
                    end
                end
                else
                begin
                    xstart     = 1'b1;
                    state_next = ST_XWAIT;
                end
            end
            ST_XWAIT:
            begin
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                if (miss)
                begin
                    sub_next = 1'b0;
                    if (edge_reg == 2'd3)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SRD;
                    end
                    else
                    begin
                        edge_next  = edge_reg + 1'b1;
                        state_next = ST_SEDGE;
                    end
                end
                else if (!sub_reg)
                begin
                    sub_next   = 1'b1;
                    state_next = ST_SEDGE;
                end
                else
                begin
                    free_next  = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_v_reg || m_tready)
                begin
                    out_v_next = 1'b1;
                    res_next   = free_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= 5'd0;
            tol_reg   <= 16'd1;
            idx_reg   <= '0;
            pass_reg  <= 1'b0;
            seg_reg   <= 1'b0;
            kind_reg  <= KIND_VERT;
            edge_reg  <= 2'd0;
            sub_reg   <= 1'b0;
            free_reg  <= 1'b1;
            res_reg   <= 1'b1;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
            seg_reg   <= seg_next;
            kind_reg  <= kind_next;
            edge_reg  <= edge_next;
            sub_reg   <= sub_next;
            free_reg  <= free_next;
            res_reg   <= res_next;
            out_v_reg <= out_v_next;
            if (cfg_we && cfg_index == CFG_COUNT)
            begin
                count_reg <= cfg_data[4:0];
            end
            if (cfg_we && cfg_index == CFG_TOLERANCE)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xs_reg <= in_xs;
            ys_reg <= in_ys;
            xe_reg <= in_xe;
            ye_reg <= in_ye;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, res_reg};

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(state_reg) == ST_OUT) else $error("stray result");
    a_xprod_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_XWAIT) |-> xrsp.done) else $error("compare not ready");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PTEST) |-> (idx_reg < active_n)) else $error("index overrun");

endmodule

/* rtl/sbcc_ram.sv */
// Generic single-port-write RAM with registered read.
// No dependencies.
module sbcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/sbcc_xprod.sv */
// Shared compare unit: sign of a*b - c*d on signed DIFF_WIDTH-bit operands.
// Products are registered, then subtracted combinationally. Uses sbcc_pkg.
module sbcc_xprod
    import sbcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  xprod_req_t req,
    output xprod_rsp_t rsp
);

    localparam int PW = 2 * DIFF_WIDTH;

    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] q_reg;
    logic                 s1_reg;
    logic signed [PW:0]   diff;

    // each product is one registered multiply
    always_ff @(posedge clk)
    begin
        p_reg <= $signed(req.a) * $signed(req.b);
        q_reg <= $signed(req.c) * $signed(req.d);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= req.start;
        end
    end

    assign diff     = (PW+1)'(p_reg) - (PW+1)'(q_reg);
    assign rsp.done = s1_reg;
    assign rsp.neg  = diff[PW];
    assign rsp.zero = (diff == '0);

endmodule

/* tb/testbench.sv */
// Testbench for segment_box_collision_check: obstacle writes, point and segment checks.
// Depends on sbcc_pkg and the RTL top; predicts results with its own obstacle table.
module testbench
    import sbcc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBOX = 16;
    localparam int DW = 264;

    typedef struct {
        logic [1:0]         op;
        logic [3:0]         idx;
        logic signed [31:0] bl, br, bb, bt, xs, ys, xe, ye;
    } query_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_COUNT;
    logic [15:0] cfg_data = '0;

    segment_box_collision_check i_dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic signed [31:0] tbl_l[NBOX], tbl_r[NBOX], tbl_b[NBOX], tbl_t[NBOX];
    int  active_boxes = 0;
    longint tol = 1;

    query_t pending_q[$];
    bit     free_q[$];
    int     errors = 0;
    int     sent = 0;
    int     hold_off = 0;
    longint cycles = 0;

    function automatic void queue_item(query_t q);
        pending_q = {pending_q, q};
    endfunction

    function automatic bit point_clear(longint x, longint y);
        for (int i = 0; i < active_boxes; i++)
            if (x >= tbl_l[i] && x <= tbl_r[i] && y >= tbl_b[i] && y <= tbl_t[i])
                return 0;
        return 1;
    endfunction

    // sign of a*b - c*d, exact at 128 bits
    function automatic int prod_sign(longint a, longint b, longint c, longint d);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b) - 128'(c) * 128'(d);
        return p < 0 ? -1 : (p == 0 ? 0 : 1);
    endfunction

    function automatic bit crosses_edge(longint e, longint lo, longint hi, longint a0,
                                        longint a1, longint b0, longint da, longint db);
        int s;
        s = da > 0 ? 1 : -1;
        if (!((e >= a0 && e <= a1) || (e >= a1 && e <= a0))) return 0;
        if (s * prod_sign(lo - b0, da, db, e - a0) > 0) return 0;
        if (s * prod_sign(hi - b0, da, db, e - a0) < 0) return 0;
        return 1;
    endfunction

    function automatic bit spans(longint s, longint e, longint lo, longint hi);
        return (s >= lo && s <= hi) || (e >= lo && e <= hi) ||
               (s <= lo && e >= hi) || (e <= lo && s >= hi);
    endfunction

    function automatic bit segment_clear(longint xs, longint ys, longint xe, longint ye);
        longint dx, dy, l, r, b, t;
        int kind;
        dx = xe - xs;
        dy = ye - ys;
        if (!point_clear(xs, ys) || !point_clear(xe, ye)) return 0;
        if (dx == 0 || (dx < 0 ? -dx : dx) < tol) kind = KIND_VERT;
        else if (dy == 0 || (dy < 0 ? -dy : dy) < tol) kind = KIND_HORIZ;
        else kind = KIND_GEN;
        for (int i = 0; i < active_boxes; i++) begin
            l = tbl_l[i]; r = tbl_r[i]; b = tbl_b[i]; t = tbl_t[i];
            if (kind == KIND_VERT) begin
                if (xe >= l && xe <= r && spans(ys, ye, b, t)) return 0;
            end
            else if (kind == KIND_HORIZ) begin
                if (ye >= b && ye <= t && spans(xs, xe, l, r)) return 0;
            end
            else begin
                if (crosses_edge(l, b, t, xs, xe, ys, dx, dy)) return 0;
                if (crosses_edge(r, b, t, xs, xe, ys, dx, dy)) return 0;
                if (crosses_edge(b, l, r, ys, ye, xs, dy, dx)) return 0;
                if (crosses_edge(t, l, r, ys, ye, xs, dy, dx)) return 0;
            end
        end
        return 1;
    endfunction

    function automatic logic [DW-1:0] pack_query(query_t q);
        return {2'b0, q.ye, q.xe, q.ys, q.xs, q.bt, q.bb, q.br, q.bl, q.idx, q.op};
    endfunction

    // predict on acceptance, in request order
    function automatic void predict(query_t q);
        if (q.op == OP_WRITE) begin
            tbl_l[q.idx] = q.bl; tbl_r[q.idx] = q.br;
            tbl_b[q.idx] = q.bb; tbl_t[q.idx] = q.bt;
        end
        else if (q.op == OP_SEGMENT)
            free_q = {free_q, segment_clear(q.xs, q.ys, q.xe, q.ye)};
        else if (q.op == OP_POINT)
            free_q = {free_q, point_clear(q.xs, q.ys)};
    endfunction

    // driver
    int gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                predict(pending_q.pop_front());
                sent++;
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                  : $urandom_range(0, 2);
                if ($urandom_range(0, 3) == 0) gap = 0;
            end
            if ((!s_tvalid || s_tready) && !(s_tvalid && gap > 0 && !s_tready)) begin
                if (gap > 0) begin
                    gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_query(pending_q[0]);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n) begin
            cycles++;
            if (m_tvalid && m_tready) begin
                if (free_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual path_free=%0d",
                             $time, m_tdata[0]);
                    errors++;
                end
                else begin
                    if (m_tdata[0] !== free_q[0]) begin
                        $display("%0t: path_free mismatch, expected %0d, actual %0d",
                                 $time, free_q[0], m_tdata[0]);
                        errors++;
                    end
                    void'(free_q.pop_front());
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 19) == 0)
                hold_off = $urandom_range(10, 60);
            else
                m_tready <= ($urandom_range(0, 3) != 0) || (cycles % 2000 < 500);
        end
    end

    always @(posedge clk) begin
        if (cycles > 3000000) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2, 3: return $signed($urandom_range(0, 400) << 12) - 32'sd819200;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic query_t make_box(int i);
        query_t q;
        logic signed [31:0] a, b, c, d;
        q = '{default: '0};
        a = rand_coord(); b = rand_coord(); c = rand_coord(); d = rand_coord();
        q.op = OP_WRITE;
        q.idx = 4'(i);
        q.bl = a < b ? a : b; q.br = a < b ? b : a;
        q.bb = c < d ? c : d; q.bt = c < d ? d : c;
        if ($urandom_range(0, 9) == 0) begin q.bl = q.br + 1; end  // inverted box
        return q;
    endfunction

    function automatic query_t make_check();
        query_t q;
        q = '{default: '0};
        q.op = $urandom_range(0, 2) == 0 ? OP_POINT : OP_SEGMENT;
        q.xs = rand_coord(); q.ys = rand_coord();
        q.xe = rand_coord(); q.ye = rand_coord();
        q.bl = $urandom(); q.br = $urandom(); q.idx = 4'($urandom());
        case ($urandom_range(0, 5))
            0: q.xe = q.xs + $signed($urandom_range(0, 3)) - 1;
            1: q.ye = q.ys;
            2: q.xe = q.xs;
            default: ;
        endcase
        return q;
    endfunction

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_COUNT) active_boxes = val[4:0] > NBOX ? NBOX : int'(val[4:0]);
        else tol = val;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || free_q.size() > 0 || s_tvalid) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    initial begin
        query_t q;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // fill the whole table, then directed checks with count 0
        for (int i = 0; i < NBOX; i++) begin
            q = make_box(i);
            if (i == 0) begin
                q.bl = -32'sd65536; q.br = 32'sd65536; q.bb = -32'sd65536; q.bt = 32'sd65536;
            end
            queue_item(q);
        end
        q = '{default: '0};
        q.op = OP_RESERVED; q.xs = '1; q.ys = '1; q.idx = '1;   // unused code, ignored
        queue_item(q);
        q.op = OP_POINT; q.xs = 0; q.ys = 0;
        queue_item(q);
        drain();

        write_reg(CFG_COUNT, 16'd1);
        write_reg(CFG_TOLERANCE, 16'd0);
        q = '{default: '0};
        q.op = OP_POINT; q.xs = 32'sd65536; q.ys = -32'sd65536;        // corner, inside
        queue_item(q);
        q.xs = 32'sd65537;                                             // just outside
        queue_item(q);
        q.op = OP_SEGMENT; q.xs = 32'sd200000; q.ys = -32'sd200000;
        q.xe = 32'sd200000; q.ye = 32'sd200000;                        // vertical miss
        queue_item(q);
        q.xs = -32'sd200000; q.xe = 32'sd200000; q.ys = 0; q.ye = 0;   // horizontal hit
        queue_item(q);
        q.xs = -32'sd200000; q.ys = -32'sd190000;
        q.xe = 32'sd200000; q.ye = 32'sd210000;                        // general hit
        queue_item(q);
        q.xs = 32'sh8000_0000; q.ys = 32'sh8000_0000;
        q.xe = 32'sh7fff_ffff; q.ye = 32'sh7fff_fffe;                  // extremes
        queue_item(q);
        drain();

        // random phases through several register settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_COUNT, ph == 0 ? 16'd31 :
                      (ph == 1 ? 16'd0 : 16'($urandom_range(0, 17))));
            write_reg(CFG_TOLERANCE, ph == 2 ? 16'hffff :
                      (ph == 3 ? 16'd0 : 16'($urandom_range(0, 4096))));
            for (int k = 0; k < 48; k++) begin
                if ($urandom_range(0, 7) == 0)
                    queue_item(make_box($urandom_range(0, NBOX - 1)));
                else
                    queue_item(make_check());
            end
            if (ph == 4) begin
                wait (pending_q.size() < 40);
                hold_off = 400;   // receiver stalls, sender keeps offering
            end
            drain();
        end

        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

/* segment_box_collision_check.f */
rtl/sbcc_pkg.sv
rtl/sbcc_ram.sv
rtl/sbcc_xprod.sv
rtl/segment_box_collision_check.sv
tb/testbench.sv
